// ===== rtl/fbpa_pkg.sv =====
// Shared types, constants and helpers for the fixed block pool allocator.
// No dependencies; imported by the queue, front end, back end and top level.
package fbpa_pkg;

  localparam int MAX_BLOCKS = 8192;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int LINK_W     = IDX_W + 1;
  localparam int ALIGNMENT  = 8;          // power of two
  localparam int POOL_LIMIT = 65535;

  localparam logic [LINK_W-1:0] NULL_LINK      = {LINK_W{1'b1}};
  localparam logic [15:0]       COUNT_DIVIDEND = 16'hFFFF;
  localparam logic [16:0]       ALIGN_MASK     = 17'(ALIGNMENT - 1);

  localparam logic [1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_SZ  = 2'd1;
  localparam logic [1:0] CFG_DEFAULT_CNT = 2'd2;

  typedef enum logic [1:0] {
    ST_GRANTED = 2'd0,
    ST_REFUSED = 2'd1,
    ST_FREED   = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_ALLOC_DEFAULT = 2'd0,
    CMD_ALLOC_OWN     = 2'd1,
    CMD_FREE          = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] req;
    logic [31:0] offset;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [31:0]       block_address;
    logic [15:0]       block_size;
    logic [IDX_W-1:0]  block_count;
    logic              free_available;
  } result_t;

  function automatic logic [16:0] round_up(input logic [15:0] sz);
    round_up = ({1'b0, sz} + ALIGN_MASK) & ~ALIGN_MASK;
  endfunction

endpackage

// ===== rtl/fbpa_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fbpa_div.sv =====
// 16-bit restoring divider, one quotient bit per cycle.
// Standalone; used by the back end for count and block index.
module fbpa_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);

  logic [15:0] rem;
  logic [15:0] quo;
  logic [15:0] dvs;
  logic [4:0]  cnt;
  logic        active;
  logic [16:0] trial;

  assign trial    = {rem, quo[15]};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= !start && active && (cnt == 5'd1);
      if (start) begin
        active <= 1'b1;
        cnt    <= 5'd16;
        rem    <= '0;
        quo    <= dividend;
        dvs    <= divisor;
      end else if (active) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= 16'(trial - {1'b0, dvs});
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= trial[15:0];
          quo <= {quo[14:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/fbpa_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on fbpa_pkg for the command type.
module fbpa_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fbpa_pkg::cmd_t push_entry,
  output logic          full,
  input  logic          pop,
  output fbpa_pkg::cmd_t pop_entry,
  output logic          not_empty
);
  import fbpa_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/fbpa_front.sv =====
// Front end: takes items, classifies them and hands them to the queue.
// Depends on fbpa_pkg for the command type and kinds.
module fbpa_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  logic           op,
  input  logic [15:0]    request_size,
  input  logic [31:0]    address,
  input  logic [31:0]    pool_base,
  input  logic [15:0]    dflt_block_size,
  input  logic           q_full,
  output logic           q_push,
  output fbpa_pkg::cmd_t q_entry
);
  import fbpa_pkg::*;

  logic held;
  cmd_t hold;
  cmd_t classified;
  logic accept;

  assign busy    = held && q_full;
  assign accept  = start && !busy;
  assign q_push  = held && !q_full;
  assign q_entry = hold;

  always_comb begin
    classified.req    = request_size;
    classified.offset = address - pool_base;
    if (op) begin
      classified.kind = CMD_FREE;
    end else if (request_size < dflt_block_size) begin
      classified.kind = CMD_ALLOC_DEFAULT;
    end else begin
      classified.kind = CMD_ALLOC_OWN;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (q_push) begin
      held <= 1'b0;
    end
  end

endmodule

// ===== rtl/fbpa_back.sv =====
// Back end: pool set-up, free-list pop/push and result formation.
// Depends on fbpa_pkg, fbpa_div and fbpa_ram (link memory).
module fbpa_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  fbpa_pkg::cmd_t    q_entry,
  output logic              q_pop,
  input  logic [31:0]       pool_base,
  input  logic [15:0]       dflt_block_size,
  input  logic [15:0]       default_block_count,
  output logic              done,
  output fbpa_pkg::result_t result
);
  import fbpa_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CDIV  = 10'b0000000010,
    S_CHECK = 10'b0000000100,
    S_APPLY = 10'b0000001000,
    S_TAKE  = 10'b0000010000,
    S_POP   = 10'b0000100000,
    S_MUL   = 10'b0001000000,
    S_ADDR  = 10'b0010000000,
    S_FDIV  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t            state;
  cmd_t              cmd;
  logic              is_ready;
  logic [15:0]       block_bytes;
  logic [IDX_W-1:0]  block_total;
  logic [IDX_W-1:0]  untouched_left;
  logic [LINK_W-1:0] stack_head;
  logic [15:0]       pool_bytes;
  logic [16:0]       setup_size;
  logic [15:0]       setup_count;
  logic [31:0]       setup_prod;
  logic [IDX_W-1:0]  take_idx;
  logic [IDX_W+15:0] addr_prod;
  status_t           res_status;
  logic [31:0]       res_addr;

  logic              need_setup;
  logic              free_hit;
  logic              setup_ok;
  logic              div_start;
  logic [15:0]       div_dividend;
  logic [15:0]       div_divisor;
  logic              div_done;
  logic [15:0]       div_quotient;
  logic              ram_we;
  logic [LINK_W-1:0] ram_rdata;

  assign need_setup = !is_ready && (q_entry.req != 16'd0) && (q_entry.kind != CMD_FREE);
  assign free_hit   = is_ready && (q_entry.offset < {16'd0, pool_bytes});
  assign q_pop      = (state == S_IDLE) && q_valid;
  assign div_start  = q_pop && ((q_entry.kind == CMD_FREE) ? free_hit
                               : (need_setup && q_entry.kind == CMD_ALLOC_OWN));
  assign div_dividend = (q_entry.kind == CMD_FREE) ? q_entry.offset[15:0] : COUNT_DIVIDEND;
  assign div_divisor  = (q_entry.kind == CMD_FREE) ? block_bytes : q_entry.req;
  assign ram_we       = (state == S_FDIV) && div_done;

  assign setup_ok = (setup_size != 17'd0) && !setup_size[16] && (setup_count != 16'd0)
                 && (setup_prod <= 32'(POOL_LIMIT)) && (setup_count <= 16'(MAX_BLOCKS));

  fbpa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  fbpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_BLOCKS)
  ) u_links (
    .clk   (clk),
    .we    (ram_we),
    .waddr (div_quotient[IDX_W-1:0]),
    .wdata (stack_head),
    .raddr (stack_head[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      is_ready       <= 1'b0;
      block_bytes    <= '0;
      block_total    <= '0;
      untouched_left <= '0;
      stack_head     <= NULL_LINK;
      pool_bytes     <= '0;
      done           <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd <= q_entry;
            if (q_entry.kind == CMD_FREE) begin
              if (free_hit) begin
                state <= S_FDIV;
              end else begin
                res_status <= ST_IGNORED;
                res_addr   <= '0;
                state      <= S_DONE;
              end
            end else if (need_setup) begin
              if (q_entry.kind == CMD_ALLOC_DEFAULT) begin
                setup_size  <= round_up(dflt_block_size);
                setup_count <= default_block_count;
                state       <= S_CHECK;
              end else begin
                setup_size <= round_up(q_entry.req);
                state      <= S_CDIV;
              end
            end else begin
              state <= S_TAKE;
            end
          end
        end
        S_CDIV: begin
          if (div_done) begin
            setup_count <= div_quotient;
            state       <= S_CHECK;
          end
        end
        S_CHECK: begin
          setup_prod <= 32'(setup_size[15:0]) * 32'(setup_count);
          state      <= S_APPLY;
        end
        S_APPLY: begin
          if (setup_ok) begin
            is_ready       <= 1'b1;
            block_bytes    <= setup_size[15:0];
            block_total    <= setup_count[IDX_W-1:0];
            untouched_left <= setup_count[IDX_W-1:0];
            stack_head     <= NULL_LINK;
            pool_bytes     <= setup_prod[15:0];
          end
          state <= S_TAKE;
        end
        S_TAKE: begin
          if (is_ready && cmd.req <= block_bytes && stack_head != NULL_LINK) begin
            take_idx <= stack_head[IDX_W-1:0];
            state    <= S_POP;
          end else if (is_ready && cmd.req <= block_bytes && untouched_left != '0) begin
            untouched_left <= untouched_left - IDX_W'(1);
            take_idx       <= untouched_left - IDX_W'(1);
            state          <= S_MUL;
          end else begin
            res_status <= ST_REFUSED;
            res_addr   <= '0;
            state      <= S_DONE;
          end
        end
        S_POP: begin
          stack_head <= ram_rdata;
          state      <= S_MUL;
        end
        S_MUL: begin
          addr_prod <= (IDX_W+16)'(take_idx) * (IDX_W+16)'(block_bytes);
          state     <= S_ADDR;
        end
        S_ADDR: begin
          res_status <= ST_GRANTED;
          res_addr   <= pool_base + 32'(addr_prod);
          state      <= S_DONE;
        end
        S_FDIV: begin
          if (div_done) begin
            stack_head <= {1'b0, div_quotient[IDX_W-1:0]};
            res_status <= ST_FREED;
            res_addr   <= '0;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          result.status         <= res_status;
          result.block_address  <= res_addr;
          result.block_size     <= block_bytes;
          result.block_count    <= block_total;
          result.free_available <= (stack_head != NULL_LINK) || (untouched_left != '0);
          state                 <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_ready_size: assert property (@(posedge clk) disable iff (rst)
    is_ready |-> (block_bytes != 16'd0 && pool_bytes != 16'd0))
    else $error("pool set up with zero size");

  a_untouched_bound: assert property (@(posedge clk) disable iff (rst)
    untouched_left <= block_total)
    else $error("untouched blocks exceed pool count");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_CDIV || state == S_FDIV))
    else $error("divider finished with no waiting step");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_push_ready: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> is_ready)
    else $error("link written before pool set-up");

endmodule

// ===== rtl/fixed_block_pool_allocator_unit.sv =====
// Top level of the fixed block pool allocator: configuration registers,
// front end, command queue and back end. Depends on fbpa_pkg and submodules.
//
// Usage: an item (op, request_size, address) is taken at a rising edge with
// start high and busy low. Each item yields one result, shown for exactly
// one cycle with done high; the receiver cannot stall it.
// Configuration: cfg_write with cfg_index 0 (pool_base), 1 (default block
// size), 2 (default block count) writes cfg_data at once; other indexes are
// dropped. Write only while no item is in flight.
// An allocate from a pool already set up takes a block off the free stack
// when one is there, else the next untouched block, and forms its address
// with a multiply; a refused allocate skips those steps. A free inside the
// pool finds its block index with the divider; a free outside it is ignored.
// The first allocate also sets up the pool, taking the block count from the
// divider when the request sets its own block size.
// Items are worked one at a time; the front end and a two-entry queue take
// up to three items ahead, and busy rises only when those are full.
// Reset (rst, synchronous) clears the pool to uninitialized and the config
// to base 0, size 64, count 256. Link memory needs no clearing pass.
module fixed_block_pool_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [15:0] request_size,
  input  logic [31:0] address,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] block_address,
  output logic [15:0] current_block_size,
  output logic [12:0] current_block_count,
  output logic        free_available
);
  import fbpa_pkg::*;

  logic [31:0] pool_base;
  logic [15:0] dflt_block_size;
  logic [15:0] default_block_count;
  logic        q_push;
  cmd_t        push_entry;
  logic        q_full;
  logic        q_pop;
  cmd_t        pop_entry;
  logic        q_valid;
  result_t     result;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base           <= '0;
      dflt_block_size     <= 16'd64;
      default_block_count <= 16'd256;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_POOL_BASE:   pool_base           <= cfg_data;
        CFG_DEFAULT_SZ:  dflt_block_size     <= cfg_data[15:0];
        CFG_DEFAULT_CNT: default_block_count <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  fbpa_front u_front (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .op              (op),
    .request_size    (request_size),
    .address         (address),
    .pool_base       (pool_base),
    .dflt_block_size (dflt_block_size),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_entry         (push_entry)
  );

  fbpa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .not_empty  (q_valid)
  );

  fbpa_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .q_valid             (q_valid),
    .q_entry             (pop_entry),
    .q_pop               (q_pop),
    .pool_base           (pool_base),
    .dflt_block_size     (dflt_block_size),
    .default_block_count (default_block_count),
    .done                (done),
    .result              (result)
  );

  assign status              = result.status;
  assign block_address       = result.block_address;
  assign current_block_size  = result.block_size;
  assign current_block_count = result.block_count;
  assign free_available      = result.free_available;

endmodule

// ===== tb/tb_fixed_block_pool_allocator_unit.sv =====
// Self-checking testbench for fixed_block_pool_allocator_unit: allocate and free items
// go in, and each result is checked field by field against an in-bench model of the pool.
// Depends on fbpa_pkg and the allocator RTL.
module tb_fixed_block_pool_allocator_unit;
  import fbpa_pkg::*;

  localparam logic       OP_ALLOC     = 1'b0;
  localparam logic       OP_FREE      = 1'b1;
  localparam logic [1:0] CFG_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 1120;
  localparam int         CYCLE_LIMIT  = 1000000;
  localparam int         DRAIN_CYCLES = 40;

  typedef struct packed {
    logic        op;
    logic [15:0] size;
    logic [31:0] addr;
  } pool_req_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        start        = 1'b0;
  logic        op           = 1'b0;
  logic [15:0] request_size = '0;
  logic [31:0] address      = '0;
  logic        cfg_write    = 1'b0;
  logic [1:0]  cfg_index    = '0;
  logic [31:0] cfg_data     = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [31:0] block_address;
  logic [15:0] current_block_size;
  logic [12:0] current_block_count;
  logic        free_available;

  // model of the pool
  logic [31:0]       cfg_base   = 32'd0;
  logic [15:0]       cfg_dsize  = 16'd64;
  logic [15:0]       cfg_dcount = 16'd256;
  logic              pool_ready = 1'b0;
  logic [15:0]       blk_bytes  = '0;
  logic [12:0]       blk_total  = '0;
  logic [12:0]       untouched  = '0;
  logic [LINK_W-1:0] stack_top  = NULL_LINK;
  logic [LINK_W-1:0] links [MAX_BLOCKS];

  int        granted_blocks[$];
  pool_req_t queued_requests[$];
  result_t   expected_results[$];
  int        mismatches = 0;
  int        cycles     = 0;
  int        idle_left  = 0;
  int        quiet_left = 0;

  fixed_block_pool_allocator_unit i_dut (
    .clk, .rst, .start, .busy, .op, .request_size, .address,
    .cfg_write, .cfg_index, .cfg_data,
    .done, .status, .block_address, .current_block_size, .current_block_count,
    .free_available
  );

  always #2 clk = ~clk;

  function automatic void set_up_pool(input int unsigned sz, input int unsigned cnt);
    longint unsigned rsz;
    rsz = (sz + ALIGNMENT - 1) / ALIGNMENT * ALIGNMENT;
    if (pool_ready || rsz == 0 || rsz > 65535 || cnt == 0) return;
    if (rsz * cnt > POOL_LIMIT || cnt > MAX_BLOCKS) return;
    pool_ready = 1'b1;
    blk_bytes  = rsz[15:0];
    blk_total  = cnt[12:0];
    untouched  = cnt[12:0];
    stack_top  = NULL_LINK;
  endfunction

  function automatic result_t allocator_outcome(input pool_req_t rq);
    result_t     res;
    int unsigned idx;
    logic [31:0] offset;
    logic        got;
    res.status        = ST_REFUSED;
    res.block_address = '0;
    got               = 1'b0;
    idx               = 0;
    if (rq.op == OP_ALLOC) begin
      if (!pool_ready && rq.size != 0) begin
        if (rq.size < cfg_dsize) set_up_pool(cfg_dsize, cfg_dcount);
        else set_up_pool(rq.size, COUNT_DIVIDEND / rq.size);
      end
      if (pool_ready && rq.size <= blk_bytes) begin
        if (stack_top != NULL_LINK && stack_top < MAX_BLOCKS) begin
          idx       = stack_top;
          stack_top = links[stack_top];
          got       = 1'b1;
        end else begin
          stack_top = NULL_LINK;
          if (untouched != 0) begin
            untouched--;
            idx = untouched;
            got = 1'b1;
          end
        end
      end
      if (got) begin
        res.status        = ST_GRANTED;
        res.block_address = cfg_base + 32'(idx) * 32'(blk_bytes);
        granted_blocks.push_back(idx);
      end
    end else begin
      res.status = ST_IGNORED;
      offset     = rq.addr - cfg_base;
      if (pool_ready && blk_bytes != 0 && offset < 32'(blk_bytes) * 32'(blk_total)) begin
        idx = offset / blk_bytes;
        if (idx < MAX_BLOCKS) begin
          links[idx] = stack_top;
          stack_top  = idx[LINK_W-1:0];
          res.status = ST_FREED;
        end
      end
    end
    res.block_size     = blk_bytes;
    res.block_count    = blk_total;
    res.free_available = (stack_top != NULL_LINK) || (untouched != 0);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) quiet_left = $urandom_range(10, 40);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // driver
  always @(posedge clk) begin
    pool_req_t nxt;
    if (rst) begin
      start     <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy)
        expected_results.push_back(allocator_outcome(pool_req_t'{op, request_size, address}));
      if (!start || !busy) begin
        if (idle_left > 0) begin
          start <= 1'b0;
          idle_left--;
        end else if (queued_requests.size() != 0) begin
          nxt          = queued_requests.pop_front();
          op           <= nxt.op;
          request_size <= nxt.size;
          address      <= nxt.addr;
          start        <= 1'b1;
          idle_left    = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding: status %0d", status);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
        if (block_address !== want.block_address) begin
          $error("block_address: expected %h, got %h", want.block_address, block_address);
          mismatches++;
        end
        if (current_block_size !== want.block_size) begin
          $error("current_block_size: expected %0d, got %0d", want.block_size,
                 current_block_size);
          mismatches++;
        end
        if (current_block_count !== want.block_count) begin
          $error("current_block_count: expected %0d, got %0d", want.block_count,
                 current_block_count);
          mismatches++;
        end
        if (free_available !== want.free_available) begin
          $error("free_available: expected %0d, got %0d", want.free_available,
                 free_available);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void add_item(input logic o, input logic [15:0] s, input logic [31:0] a);
    queued_requests.push_back(pool_req_t'{o, s, a});
  endfunction

  function automatic logic [31:0] block_start(input int idx);
    return cfg_base + 32'(idx) * 32'(blk_bytes);
  endfunction

  function automatic void free_granted(input bit last_byte);
    int k;
    int idx;
    k   = $urandom_range(0, granted_blocks.size() - 1);
    idx = granted_blocks[k];
    granted_blocks.delete(k);
    add_item(OP_FREE, 16'($urandom()), block_start(idx) +
             (last_byte ? 32'(blk_bytes) - 32'd1 : 32'($urandom_range(0, blk_bytes - 1))));
  endfunction

  task automatic drain();
    while (queued_requests.size() != 0 || start) @(negedge clk);
  endtask

  task automatic settle();
    drain();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_POOL_BASE:   cfg_base   = val;
      CFG_DEFAULT_SZ:  cfg_dsize  = val[15:0];
      CFG_DEFAULT_CNT: cfg_dcount = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int unsigned dsize;
    int unsigned dcount;
    int unsigned rsz;
    int unsigned req;
    int          k;
    int          sent;
    int          moves;
    logic [31:0] base;
    logic [31:0] a;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // pool not set up yet
    add_item(OP_FREE, 16'd0, 32'd0);
    add_item(OP_FREE, 16'hFFFF, 32'hFFFF_FFFF);
    add_item(OP_ALLOC, 16'd0, 32'd0);
    settle();

    // defaults too big: every set-up attempt fails
    write_reg(CFG_DEFAULT_SZ, 32'h0000_FFFF);
    write_reg(CFG_DEFAULT_CNT, 32'h0000_FFFF);
    write_reg(CFG_UNUSED, $urandom());
    add_item(OP_ALLOC, 16'd1, $urandom());
    add_item(OP_ALLOC, 16'hFFFF, $urandom());
    add_item(OP_ALLOC, 16'd100, $urandom());
    settle();

    // pool geometry for this run
    case ($urandom_range(0, 5))
      0: begin dsize = 64;    dcount = 256;  end
      1: begin dsize = 8;     dcount = 8191; end
      2: begin dsize = 65528; dcount = 1;    end
      default: begin
        dsize  = $urandom_range(1, 4096);
        rsz    = (dsize + ALIGNMENT - 1) / ALIGNMENT * ALIGNMENT;
        k      = 65535 / rsz;
        dcount = $urandom_range(1, (k < 32) ? k : 32);
      end
    endcase
    rsz = (dsize + ALIGNMENT - 1) / ALIGNMENT * ALIGNMENT;
    case ($urandom_range(0, 3))
      0:       base = 32'd0;
      1:       base = 32'hFFFF_FFFF;
      2:       base = 32'hFFFF_F000;
      default: base = $urandom();
    endcase
    write_reg(CFG_POOL_BASE, base);
    write_reg(CFG_DEFAULT_SZ, dsize);
    write_reg(CFG_DEFAULT_CNT, dcount);
    // below the default size takes the default geometry, otherwise the request's own
    req = (dsize > 1 && $urandom_range(0, 1)) ? $urandom_range(1, dsize - 1) : rsz;
    add_item(OP_ALLOC, req[15:0], $urandom());
    settle();

    add_item(OP_ALLOC, blk_bytes, $urandom());
    add_item(OP_ALLOC, blk_bytes + 16'd1, $urandom());
    add_item(OP_ALLOC, 16'hFFFF, $urandom());
    add_item(OP_ALLOC, 16'd0, $urandom());
    add_item(OP_FREE, 16'($urandom()), cfg_base - 32'd1);
    add_item(OP_FREE, 16'($urandom()), block_start(blk_total));
    if (blk_total <= 8) repeat (blk_total + 1) add_item(OP_ALLOC, 16'd1, $urandom());
    settle();
    if (granted_blocks.size() != 0) free_granted(1'b1);
    add_item(OP_ALLOC, 16'd1, $urandom());
    settle();

    sent  = 0;
    moves = 0;
    while (sent < RANDOM_ITEMS) begin
      repeat ($urandom_range(1, 16)) begin
        k = $urandom_range(0, 99);
        if (k < 52) begin
          add_item(OP_ALLOC, ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, blk_bytes))
                                                         : 16'($urandom()), $urandom());
          sent++;
        end else if (k < 90 && granted_blocks.size() != 0) begin
          free_granted(1'b0);
          sent++;
        end else begin
          case ($urandom_range(0, 2))
            0:       a = $urandom();
            1:       a = cfg_base - 32'd1;
            default: a = block_start(blk_total);
          endcase
          add_item(OP_FREE, 16'($urandom()), a);
          sent++;
        end
      end
      drain();
      if (moves == 0 && sent >= RANDOM_ITEMS / 3) begin
        settle();
        write_reg(CFG_POOL_BASE, 32'hFFFF_FFFF);
        write_reg(CFG_DEFAULT_SZ, 32'd1);
        write_reg(CFG_DEFAULT_CNT, 32'd1);
        moves = 1;
      end else if (moves == 1 && sent >= 2 * RANDOM_ITEMS / 3) begin
        settle();
        write_reg(CFG_POOL_BASE, 32'd0);
        write_reg(CFG_DEFAULT_SZ, $urandom());
        write_reg(CFG_DEFAULT_CNT, $urandom());
        moves = 2;
      end
    end

    // misuse kept to the end: it can loop the free stack for good
    settle();
    add_item(OP_FREE, 16'($urandom()), block_start($urandom_range(0, blk_total - 1)));
    if (granted_blocks.size() != 0) begin
      k = granted_blocks[0];
      add_item(OP_FREE, 16'($urandom()), block_start(k));
      add_item(OP_FREE, 16'($urandom()), block_start(k) + 32'd1);
    end
    repeat (4) add_item(OP_ALLOC, 16'($urandom_range(0, blk_bytes)), $urandom());
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
